[rtl/core/grid_ray_dda_setup_defines.svh]
// ----------------------------------------------------------------------------
// grid_ray_dda_setup_defines
// Assertion macros for the ray setup block.
// ----------------------------------------------------------------------------
`ifndef GRID_RAY_DDA_SETUP_DEFINES_SVH
`define GRID_RAY_DDA_SETUP_DEFINES_SVH
// property must hold on every cycle out of reset
`define GRD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication, consequent checked in the next cycle
`define GRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[rtl/core/grd_pkg.sv]
// ----------------------------------------------------------------------------
// grd_pkg
// Shared constants and types for the grid ray setup pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package grd_pkg;
  localparam int FracBits = 16;
  localparam int ColW = 12;
  localparam int PosW = 24;
  localparam int VecW = 18;
  localparam int RayW = 19;
  localparam int WidW = 13;
  localparam int CamW = 32;
  localparam int SqW = 38;
  localparam int LenW = 19;
  localparam int NumW = LenW + FracBits;
  localparam int QW = 32;
  // camera numerator 2*col << F
  localparam int CamNW = ColW + 1 + FracBits;
  // root payload carries both ray components
  localparam int SqPayW = 2 * RayW;

  localparam logic [2:0] RegPosX = 3'd0;
  localparam logic [2:0] RegPosY = 3'd1;
  localparam logic [2:0] RegDirX = 3'd2;
  localparam logic [2:0] RegDirY = 3'd3;
  localparam logic [2:0] RegPlaneX = 3'd4;
  localparam logic [2:0] RegPlaneY = 3'd5;
  localparam logic [2:0] RegWidth = 3'd6;

  typedef struct packed {
    logic [PosW-1:0] pos_x;
    logic [PosW-1:0] pos_y;
    logic signed [VecW-1:0] dir_x;
    logic signed [VecW-1:0] dir_y;
    logic signed [VecW-1:0] plane_x;
    logic signed [VecW-1:0] plane_y;
    logic [WidW-1:0] width;
  } cfg_t;
endpackage
`default_nettype wire

[rtl/core/grd_div.sv]
// ----------------------------------------------------------------------------
// grd_div
// Pipelined restoring divider, one quotient bit per stage, stall aware.
// Widths follow the delta path; narrower operands are zero-extended.
// Carries a side payload alongside each word.
// ----------------------------------------------------------------------------
`default_nettype none
module grd_div
  import grd_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [NumW-1:0] num,
  input  wire logic [RayW-1:0] den,
  input  wire logic [RayW-1:0] in_pay,
  output logic                 out_valid,
  output logic [NumW-1:0]      quo,
  output logic [RayW-1:0]      out_pay
);
  logic            v   [NumW+1];
  logic [NumW-1:0] q   [NumW+1];
  logic [RayW:0]   r   [NumW+1];
  logic [RayW-1:0] d   [NumW+1];
  logic [RayW-1:0] p   [NumW+1];

  assign v[0] = in_valid;
  assign q[0] = num;
  assign r[0] = '0;
  assign d[0] = den;
  assign p[0] = in_pay;

  for (genvar i = 0; i < NumW; i++) begin : g_st
    logic [RayW+1:0] sh;
    logic [RayW+1:0] df;
    assign sh = {r[i], q[i][NumW-1]};
    assign df = sh - {2'b00, d[i]};
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
      if (en) begin
        d[i+1] <= d[i];
        p[i+1] <= p[i];
        if (!df[RayW+1]) begin
          r[i+1] <= df[RayW:0];
          q[i+1] <= {q[i][NumW-2:0], 1'b1};
        end else begin
          r[i+1] <= sh[RayW:0];
          q[i+1] <= {q[i][NumW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v[NumW];
  assign quo = q[NumW];
  assign out_pay = p[NumW];
endmodule
`default_nettype wire

[rtl/core/grd_sqrt.sv]
// ----------------------------------------------------------------------------
// grd_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module grd_sqrt
  import grd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [SqW-1:0]    rad,
  input  wire logic [SqPayW-1:0] in_pay,
  output logic                   out_valid,
  output logic [LenW-1:0]        root,
  output logic [SqPayW-1:0]      out_pay
);
  logic              v [LenW+1];
  logic [SqW-1:0]    x [LenW+1];
  logic [LenW-1:0]   rr[LenW+1];
  logic [LenW+1:0]   rm[LenW+1];
  logic [SqPayW-1:0] p [LenW+1];

  assign v[0] = in_valid;
  assign x[0] = rad;
  assign rr[0] = '0;
  assign rm[0] = '0;
  assign p[0] = in_pay;

  for (genvar i = 0; i < LenW; i++) begin : g_st
    logic [LenW+1:0] tr;
    logic [LenW+1:0] tt;
    logic [LenW+1:0] df;
    assign tr = {rm[i][LenW-1:0], x[i][SqW-1:SqW-2]};
    assign tt = {rr[i], 2'b01};
    assign df = tr - tt;
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
      if (en) begin
        p[i+1] <= p[i];
        x[i+1] <= {x[i][SqW-3:0], 2'b00};
        if (tr >= tt) begin
          rm[i+1] <= df;
          rr[i+1] <= {rr[i][LenW-2:0], 1'b1};
        end else begin
          rm[i+1] <= tr;
          rr[i+1] <= {rr[i][LenW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v[LenW];
  assign root = rr[LenW];
  assign out_pay = p[LenW];
endmodule
`default_nettype wire

[rtl/core/grid_ray_dda_setup.sv]
// ----------------------------------------------------------------------------
// grid_ray_dda_setup: ray setup for a grid raycaster, one screen column per word
// Path: camera divider, root and delta dividers, plus six registered stages.
// Throughput: one column per cycle; all stages hold while the output is stalled.
// Reset: synchronous; clears valid bits and loads default camera registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "grid_ray_dda_setup_defines.svh"
module grid_ray_dda_setup
  import grd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [2:0]             cfg_index,
  input  wire logic [31:0]            cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [ColW-1:0]        column,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic signed [RayW-1:0]      ray_dir_x,
  output logic signed [RayW-1:0]      ray_dir_y,
  output logic [7:0]                  map_x,
  output logic [7:0]                  map_y,
  output logic signed [1:0]           step_x,
  output logic signed [1:0]           step_y,
  output logic [31:0]                 delta_dist_x,
  output logic [31:0]                 delta_dist_y,
  output logic [31:0]                 side_dist_x,
  output logic [31:0]                 side_dist_y
);
  cfg_t cfg;
  logic en;

  // pipeline advances when the output register is free or being emptied
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pos_x <= '0;
      cfg.pos_y <= '0;
      cfg.dir_x <= 18'sd65536;
      cfg.dir_y <= '0;
      cfg.plane_x <= '0;
      cfg.plane_y <= 18'sd43253;
      cfg.width <= 13'd640;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegPosX: cfg.pos_x <= cfg_data[PosW-1:0];
        RegPosY: cfg.pos_y <= cfg_data[PosW-1:0];
        RegDirX: cfg.dir_x <= cfg_data[VecW-1:0];
        RegDirY: cfg.dir_y <= cfg_data[VecW-1:0];
        RegPlaneX: cfg.plane_x <= cfg_data[VecW-1:0];
        RegPlaneY: cfg.plane_y <= cfg_data[VecW-1:0];
        RegWidth: cfg.width <= cfg_data[WidW-1:0];
        default: ;
      endcase
    end
  end

  // camera offset: (2*col << F) / w
  logic [WidW-1:0] wid;
  assign wid = (cfg.width == '0) ? WidW'(1) : cfg.width;
  logic cam_v;
  logic [NumW-1:0] cam_qf;
  logic [CamNW-1:0] cam_q;
  logic [RayW-1:0] cam_p;
  grd_div u_cdiv (
    .clk, .rst, .en, .in_valid(in_valid),
    .num({{(NumW-CamNW){1'b0}}, column, 1'b0, {FracBits{1'b0}}}),
    .den({{(RayW-WidW){1'b0}}, wid}), .in_pay('0),
    .out_valid(cam_v), .quo(cam_qf), .out_pay(cam_p)
  );
  assign cam_q = cam_qf[CamNW-1:0];

  // stage: products
  logic s1_v;
  logic signed [VecW+CamNW+1:0] s1_px, s1_py;
  logic signed [CamNW:0] cam;
  assign cam = $signed({1'b0, cam_q}) - $signed((CamNW+1)'(1) << FracBits);
  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (en) s1_v <= cam_v;
    if (en) begin
      s1_px <= cfg.plane_x * cam;
      s1_py <= cfg.plane_y * cam;
    end
  end

  // stage: ray direction with saturation
  logic s2_v;
  logic signed [RayW-1:0] s2_rx, s2_ry;
  function automatic logic signed [RayW-1:0] sat_ray(
    input logic signed [VecW-1:0] d, input logic signed [VecW+CamNW+1:0] pr);
    logic signed [VecW+CamNW+1:0] s;
    s = (pr >>> FracBits) + (VecW+CamNW+2)'(d);
    if (s > (VecW+CamNW+2)'(262143)) return 19'sh3FFFF;
    else if (s < -(VecW+CamNW+2)'(262144)) return 19'sh40000;
    else return s[RayW-1:0];
  endfunction
  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (en) s2_v <= s1_v;
    if (en) begin
      s2_rx <= sat_ray(cfg.dir_x, s1_px);
      s2_ry <= sat_ray(cfg.dir_y, s1_py);
    end
  end

  // stage: squares
  logic s3_v;
  logic [SqW-2:0] s3_xx, s3_yy;
  logic signed [RayW-1:0] s3_rx, s3_ry;
  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (en) s3_v <= s2_v;
    if (en) begin
      s3_xx <= (SqW-1)'(s2_rx * s2_rx);
      s3_yy <= (SqW-1)'(s2_ry * s2_ry);
      s3_rx <= s2_rx;
      s3_ry <= s2_ry;
    end
  end

  logic sq_v;
  logic [LenW-1:0] len;
  logic [SqPayW-1:0] sq_p;
  grd_sqrt u_sqrt (
    .clk, .rst, .en, .in_valid(s3_v),
    .rad({1'b0, s3_xx} + {1'b0, s3_yy}), .in_pay({s3_rx, s3_ry}),
    .out_valid(sq_v), .root(len), .out_pay(sq_p)
  );

  logic signed [RayW-1:0] q_rx, q_ry;
  logic [RayW-1:0] mx, my;
  assign q_rx = sq_p[SqPayW-1:RayW];
  assign q_ry = sq_p[RayW-1:0];
  assign mx = q_rx[RayW-1] ? RayW'(-q_rx) : RayW'(q_rx);
  assign my = q_ry[RayW-1] ? RayW'(-q_ry) : RayW'(q_ry);

  // each delta divider carries its own ray component
  logic dx_v, dy_v;
  logic [NumW-1:0] qx, qy;
  logic [RayW-1:0] dpx, dpy;
  grd_div u_dx (
    .clk, .rst, .en, .in_valid(sq_v), .num({len, {FracBits{1'b0}}}),
    .den(mx), .in_pay(q_rx), .out_valid(dx_v), .quo(qx), .out_pay(dpx)
  );
  grd_div u_dy (
    .clk, .rst, .en, .in_valid(sq_v), .num({len, {FracBits{1'b0}}}),
    .den(my), .in_pay(q_ry), .out_valid(dy_v), .quo(qy), .out_pay(dpy)
  );

  // stage: delta saturation
  logic s4_v;
  logic signed [RayW-1:0] s4_rx, s4_ry;
  logic [QW-1:0] s4_dx, s4_dy;
  function automatic logic [QW-1:0] sat_delta(
    input logic signed [RayW-1:0] r, input logic [NumW-1:0] q);
    if (r == '0 || q[NumW-1:QW] != '0) return '1;
    else return q[QW-1:0];
  endfunction
  always_ff @(posedge clk) begin
    if (rst) s4_v <= 1'b0;
    else if (en) s4_v <= dx_v;
    if (en) begin
      s4_rx <= dpx;
      s4_ry <= dpy;
      s4_dx <= sat_delta(dpx, qx);
      s4_dy <= sat_delta(dpy, qy);
    end
  end

  // stage: side products
  logic [FracBits:0] dist_x, dist_y;
  logic [FracBits-1:0] fx, fy;
  assign fx = cfg.pos_x[FracBits-1:0];
  assign fy = cfg.pos_y[FracBits-1:0];
  assign dist_x = s4_rx[RayW-1] ? {1'b0, fx} : (FracBits+1)'(1 << FracBits) - {1'b0, fx};
  assign dist_y = s4_ry[RayW-1] ? {1'b0, fy} : (FracBits+1)'(1 << FracBits) - {1'b0, fy};
  logic s5_v;
  logic signed [RayW-1:0] s5_rx, s5_ry;
  logic [QW-1:0] s5_dx, s5_dy;
  logic [QW+FracBits:0] s5_px, s5_py;
  always_ff @(posedge clk) begin
    if (rst) s5_v <= 1'b0;
    else if (en) s5_v <= s4_v;
    if (en) begin
      s5_rx <= s4_rx;
      s5_ry <= s4_ry;
      s5_dx <= s4_dx;
      s5_dy <= s4_dy;
      s5_px <= dist_x * s4_dx;
      s5_py <= dist_y * s4_dy;
    end
  end

  function automatic logic [QW-1:0] sat_side(
    input logic [QW-1:0] d, input logic [QW+FracBits:0] pr);
    logic [QW:0] s;
    s = pr[QW+FracBits:FracBits];
    if (d == '1 || s[QW]) return '1;
    else return s[QW-1:0];
  endfunction

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= s5_v;
    if (en) begin
      ray_dir_x <= s5_rx;
      ray_dir_y <= s5_ry;
      map_x <= cfg.pos_x[FracBits+7:FracBits];
      map_y <= cfg.pos_y[FracBits+7:FracBits];
      step_x <= s5_rx[RayW-1] ? -2'sd1 : 2'sd1;
      step_y <= s5_ry[RayW-1] ? -2'sd1 : 2'sd1;
      delta_dist_x <= s5_dx;
      delta_dist_y <= s5_dy;
      side_dist_x <= sat_side(s5_dx, s5_px);
      side_dist_y <= sat_side(s5_dy, s5_py);
    end
  end

  `GRD_ASSERT(a_div_sync, dx_v == dy_v, "delta dividers out of step")
  `GRD_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(side_dist_x),
    "stalled result word changed")
  `GRD_ASSERT(a_step, out_valid |-> (step_x == -2'sd1) == ray_dir_x[RayW-1],
    "step sign mismatch")
  `GRD_ASSERT(a_cam_fit, !cam_v || (cam_qf[NumW-1:CamNW] == '0 && cam_p == '0),
    "camera divider overflow")
endmodule
`default_nettype wire
